>>> rtl/mpts_pkg.sv
// ----------------------------------------------------------------------------
// mpts_pkg
// Types and constants shared by the memory pattern test sequencer.
// ----------------------------------------------------------------------------
package mpts_pkg;

  localparam int OFFSET_BITS    = 24;
  localparam int WORDS_BITS     = 25;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 25;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_WORDS_IN_USE    = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CONTINUOUS_MODE = 1'd1;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_WALK_ONES  = 3'd1;
  localparam logic [2:0] PH_WALK_ZEROS = 3'd2;
  localparam logic [2:0] PH_CHECKER    = 3'd3;
  localparam logic [2:0] PH_FINISHED   = 3'd4;

  localparam logic [1:0] ST_RUNNING = 2'd0;
  localparam logic [1:0] ST_PASSED  = 2'd1;
  localparam logic [1:0] ST_FAILED  = 2'd2;

  localparam logic [31:0] CHECKER_EVEN = 32'h5555_5555;
  localparam logic [31:0] CHECKER_ODD  = 32'hAAAA_AAAA;

  typedef struct packed {
    logic        start_req;
    logic [31:0] read_data;
  } item_t;

  typedef struct packed {
    logic [1:0]             command;
    logic [OFFSET_BITS-1:0] word_offset;
    logic [31:0]            write_data;
    logic [2:0]             test_phase;
    logic [1:0]             status;
    logic                   round_toggle;
  } result_t;

endpackage

>>> rtl/memory_pattern_test_sequencer_core.sv
// ----------------------------------------------------------------------------
// memory_pattern_test_sequencer_core
// Walking ones / walking zeros / checkerboard memory self-test sequencer.
// ----------------------------------------------------------------------------
// Takes one request per clock while item_stall is low and gives one memory
// access per request; the result is registered from the step logic, so a
// memory can be driven at full rate. Read data for a read access is expected
// on the next request. The step logic sits between the sequencer state and a
// two-entry output buffer; the buffer holds one extra result, so an output
// stall does not at once stop the input side, and item_stall rises only once
// both entries are full. No clearing pass after reset.
module memory_pattern_test_sequencer_core
  import mpts_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  item_t                     item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result
);

  logic    accept;
  logic    take;
  logic    skid_valid;
  result_t skid_result;
  result_t step_result;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !skid_valid;
  assign take       = result_valid && !result_stall;

  mpts_step u_step (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .step        (accept),
    .item        (item),
    .step_result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) skid_valid <= 1'b0;
    end else if (accept) begin
      if (result_valid && !take) skid_valid <= 1'b1;
      else result_valid <= 1'b1;
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) result <= skid_result;
    end else if (accept) begin
      if (result_valid && !take) skid_result <= step_result;
      else result <= step_result;
    end
  end

  // the spare entry is only ever filled behind a held result
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry full with no result held");

  // accesses are only issued inside a test phase
  a_access_in_phase: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.command != CMD_NONE) |->
      (result.test_phase == PH_WALK_ONES || result.test_phase == PH_WALK_ZEROS ||
       result.test_phase == PH_CHECKER))
    else $error("access issued outside a test phase");

  // a failed result never carries an access
  a_failed_quiet: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_FAILED) |->
      (result.command == CMD_NONE && result.test_phase == PH_FINISHED))
    else $error("failed status with an access or unfinished phase");

  // a held result stays put while the spare entry fills
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result == $past(result)))
    else $error("stalled result changed");

endmodule

>>> rtl/mpts_step.sv
// ----------------------------------------------------------------------------
// mpts_step
// Sequencer state, configuration registers and the per-request step logic.
// ----------------------------------------------------------------------------
module mpts_step
  import mpts_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      step,
  input  item_t                     item,
  output result_t                   step_result
);

  logic [OFFSET_BITS-1:0] last_word;
  logic                   continuous_mode;

  logic [2:0]             phase, phase_next;
  logic                   verifying, verifying_next;
  logic [31:0]            pattern, pattern_next;
  logic [OFFSET_BITS-1:0] word_index, word_index_next;
  logic                   read_pending, read_pending_next;
  logic [31:0]            expected_value, expected_value_next;
  logic                   failed_flag, failed_flag_next;
  logic                   passed_toggle, passed_toggle_next;
  logic                   closing, closing_next;

  logic [OFFSET_BITS-1:0] cfg_last;

  // last tested word from the word count: even, at least 2, at most 2^OFFSET_BITS
  always_comb begin
    if (cfg_data[WORDS_BITS-1:OFFSET_BITS] != '0) begin
      cfg_last = '1;
    end else if (cfg_data[OFFSET_BITS-1:1] == '0) begin
      cfg_last = OFFSET_BITS'(1);
    end else begin
      cfg_last = {cfg_data[OFFSET_BITS-1:1] - 1'b1, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_word       <= OFFSET_BITS'(24'h7F_FFFF);
      continuous_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WORDS_IN_USE:    last_word       <= cfg_last;
        CFG_CONTINUOUS_MODE: continuous_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [2:0]  shown;
    logic [31:0] data;

    phase_next          = phase;
    verifying_next      = verifying;
    pattern_next        = pattern;
    word_index_next     = word_index;
    read_pending_next   = read_pending;
    expected_value_next = expected_value;
    failed_flag_next    = failed_flag;
    passed_toggle_next  = passed_toggle;
    closing_next        = closing;
    data                = '0;
    step_result         = '0;

    // check the read issued on the previous request
    if (read_pending) begin
      read_pending_next = 1'b0;
      if (item.read_data != expected_value) begin
        failed_flag_next = 1'b1;
        phase_next       = PH_FINISHED;
        closing_next     = 1'b0;
      end
    end

    // round complete once the final checkerboard read has passed
    if (closing_next) begin
      closing_next       = 1'b0;
      passed_toggle_next = ~passed_toggle;
      if (continuous_mode) begin
        phase_next      = PH_WALK_ONES;
        verifying_next  = 1'b0;
        pattern_next    = 32'd1;
        word_index_next = '0;
      end else begin
        phase_next = PH_FINISHED;
      end
    end

    if (phase_next == PH_IDLE && item.start_req) begin
      phase_next      = PH_WALK_ONES;
      verifying_next  = 1'b0;
      pattern_next    = 32'd1;
      word_index_next = '0;
    end

    shown = phase_next;

    if (shown == PH_WALK_ONES || shown == PH_WALK_ZEROS || shown == PH_CHECKER) begin
      if (shown == PH_CHECKER) begin
        data = word_index_next[0] ? CHECKER_ODD : CHECKER_EVEN;
      end else begin
        data = pattern_next;
      end
      step_result.word_offset = word_index_next;
      if (verifying_next) begin
        step_result.command = CMD_READ;
        read_pending_next   = 1'b1;
        expected_value_next = data;
      end else begin
        step_result.command    = CMD_WRITE;
        step_result.write_data = data;
      end

      if (word_index_next >= last_word) begin
        word_index_next = '0;
        if (!verifying_next) begin
          verifying_next = 1'b1;
        end else begin
          verifying_next = 1'b0;
          unique case (shown)
            PH_WALK_ONES: begin
              pattern_next = {pattern_next[30:0], 1'b0};
              if (pattern_next == '0) begin
                phase_next   = PH_WALK_ZEROS;
                pattern_next = ~32'd1;
              end
            end
            PH_WALK_ZEROS: begin
              pattern_next = {pattern_next[30:0], 1'b1};
              if (pattern_next == '1) begin
                phase_next   = PH_CHECKER;
                pattern_next = CHECKER_EVEN;
              end
            end
            default: closing_next = 1'b1;
          endcase
        end
      end else begin
        word_index_next = word_index_next + 1'b1;
      end
    end

    step_result.test_phase   = shown;
    step_result.status       = failed_flag_next ? ST_FAILED :
                               (shown == PH_FINISHED) ? ST_PASSED : ST_RUNNING;
    step_result.round_toggle = passed_toggle_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      verifying      <= 1'b0;
      pattern        <= 32'd1;
      word_index     <= '0;
      read_pending   <= 1'b0;
      expected_value <= '0;
      failed_flag    <= 1'b0;
      passed_toggle  <= 1'b0;
      closing        <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      verifying      <= verifying_next;
      pattern        <= pattern_next;
      word_index     <= word_index_next;
      read_pending   <= read_pending_next;
      expected_value <= expected_value_next;
      failed_flag    <= failed_flag_next;
      passed_toggle  <= passed_toggle_next;
      closing        <= closing_next;
    end
  end

endmodule
